### design/ntct_pkg.sv
// ntct_pkg: shared constants, lookup tables and types for the ntc temperature core
// no dependencies; used by ntct_muldiv and ntc_thermistor_temperature_core

package ntct_pkg;

  // default converter width
  localparam int ADC_BITS_DEF = 12;

  // field and register widths
  localparam int CFG_W   = 20;
  localparam int OHM_W   = 24;
  localparam int TEMP_W  = 15;
  localparam int DT_W    = 12;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(10000);
  localparam logic [OHM_W-1:0] RES_MAX   = '1;

  // resistance / temperature table, falling resistance
  localparam int TABLE_POINTS = 15;
  localparam int IDX_W        = $clog2(TABLE_POINTS);

  localparam logic [OHM_W-1:0] ROM_OHMS [TABLE_POINTS] = '{
    24'd197390, 24'd114340, 24'd68915, 24'd42889, 24'd32116,
    24'd10000,  24'd8047,   24'd6523,  24'd5318,  24'd4357,
    24'd3588,   24'd2466,   24'd1452,  24'd890,   24'd657
  };

  localparam logic signed [TEMP_W-1:0] ROM_CENTI [TABLE_POINTS] = '{
    -15'sd4000, -15'sd3000, -15'sd2000, -15'sd1000, 15'sd0,
    15'sd2500,  15'sd3000,  15'sd3500,  15'sd4000,  15'sd4500,
    15'sd5000,  15'sd6000,  15'sd7500,  15'sd9000,  15'sd10000
  };

  // temperature rise over each segment
  localparam logic [DT_W-1:0] ROM_DT [TABLE_POINTS-1] = '{
    12'd1000, 12'd1000, 12'd1000, 12'd1000, 12'd2500,
    12'd500,  12'd500,  12'd500,  12'd500,  12'd500,
    12'd1000, 12'd1500, 12'd1500, 12'd1000
  };

  // result range codes
  typedef enum logic [1:0] {
    RANGE_INTERP = 2'd0,
    RANGE_COLD   = 2'd1,
    RANGE_HOT    = 2'd2
  } range_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RES,
    ST_CLASS,
    ST_SEARCH,
    ST_INTERP,
    ST_FINISH
  } state_e;

endpackage

### design/ntct_muldiv.sv
// ntct_muldiv: bit-serial multiply then restoring divide, floor(a * b / d)
// depends on ntct_pkg for default widths

module ntct_muldiv #(
  parameter int A_W = ntct_pkg::OHM_W,
  parameter int B_W = ntct_pkg::ADC_BITS_DEF,
  parameter int D_W = ntct_pkg::OHM_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [A_W-1:0]   a_i,
  input  logic [B_W-1:0]   b_i,
  input  logic [D_W-1:0]   d_i,
  output logic             done_o,
  output logic [A_W+B_W-1:0] quot_o,
  output logic [D_W-1:0]   rem_o
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(P_W + 1);

  logic             busy_q, busy_d;
  logic             div_q, div_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [A_W-1:0]   a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [D_W-1:0]   d_q, d_d;
  logic [P_W-1:0]   acc_q, acc_d;
  logic [D_W-1:0]   rem_q, rem_d;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             qbit;

  // one divide step: shift in next numerator bit, try to subtract
  assign trial = {rem_q, acc_q[P_W-1]};
  assign diff  = trial - {1'b0, d_q};
  assign qbit  = (trial >= {1'b0, d_q});

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    d_d    = d_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      div_d  = 1'b0;
      cnt_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      d_d    = d_i;
      acc_d  = '0;
      rem_d  = '0;
    end else if (busy_q && !div_q) begin
      // shift-add multiply, multiplier msb first
      acc_d = {acc_q[P_W-2:0], 1'b0} + (b_q[B_W-1] ? P_W'(a_q) : '0);
      b_d   = {b_q[B_W-2:0], 1'b0};
      if (cnt_q == CNT_W'(B_W - 1)) begin
        div_d = 1'b1;
        cnt_d = '0;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end else if (busy_q) begin
      // restoring divide, quotient bits shift in at the bottom
      rem_d = qbit ? diff[D_W-1:0] : trial[D_W-1:0];
      acc_d = {acc_q[P_W-2:0], qbit};
      if (cnt_q == CNT_W'(P_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      div_q  <= div_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    d_q   <= d_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;
  assign rem_o  = rem_q;

  // no new operation while one is running
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("muldiv started while busy");

  // multiply phase never runs past the multiplier width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !div_q) |-> (cnt_q < CNT_W'(B_W)))
    else $error("multiply step count out of range");

  // done is a single pulse after the last divide step
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_q && div_q)
    else $error("done raised outside end of divide");

endmodule

### design/ntc_thermistor_temperature_core.sv
// ntc_thermistor_temperature_core: adc code to thermistor resistance and temperature
// depends on ntct_pkg and ntct_muldiv
//
//   channel   signals                                      direction
//   input     in_valid_i, in_stall_o, adc_code_i           in
//   output    out_valid_o, out_stall_i, temperature_centi_o,
//             resistance_ohms_o, range_status_o            out
//   config    cfg_we_i, cfg_wdata_i                        in
//
// one item at a time; the shared serial multiply/divide unit runs twice per item,
// with operand widths A = 24 and B = max(ADC_BITS, 12); between the passes a
// binary search takes up to four halving steps and one that starts interpolation,
// and the sequencer steps through accept, classify and finish.
// full-scale codes and clamped results skip one or both passes.
// reset is asynchronous and active low; the series resistor resets to 10000 ohms.
// a finished item waits in the output register while the next item is taken.

module ntc_thermistor_temperature_core #(
  parameter int ADC_BITS = ntct_pkg::ADC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ntct_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ADC_BITS-1:0]               adc_code_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ntct_pkg::TEMP_W-1:0] temperature_centi_o,
  output logic [ntct_pkg::OHM_W-1:0]        resistance_ohms_o,
  output logic [1:0]                        range_status_o
);

  localparam int OHM_W  = ntct_pkg::OHM_W;
  localparam int TEMP_W = ntct_pkg::TEMP_W;
  localparam int IDX_W  = ntct_pkg::IDX_W;
  localparam int A_W    = OHM_W;
  localparam int B_W    = (ADC_BITS > ntct_pkg::DT_W) ? ADC_BITS : ntct_pkg::DT_W;
  localparam int D_W    = OHM_W;
  localparam int P_W    = A_W + B_W;

  localparam logic [ADC_BITS-1:0] FULL = '1;

  ntct_pkg::state_e state_q, state_d;
  ntct_pkg::range_e status_q, status_d;
  ntct_pkg::range_e out_status_q;

  logic [ntct_pkg::CFG_W-1:0] cfg_q;
  logic [OHM_W-1:0]           r_q, r_d;
  logic [IDX_W-1:0]           lo_q, lo_d, hi_q, hi_d, lo_nx, mid;
  logic [IDX_W:0]             mid_sum;
  logic signed [TEMP_W-1:0]   t1_q, t1_d, temp_q, temp_d;
  logic signed [TEMP_W:0]     isum, iadj;
  logic                       neg_frac;

  logic                       out_valid_q, out_load;
  logic signed [TEMP_W-1:0]   out_temp_q;
  logic [OHM_W-1:0]           out_res_q;

  logic                       md_start, md_done;
  logic [A_W-1:0]             md_a;
  logic [B_W-1:0]             md_b;
  logic [D_W-1:0]             md_d;
  logic [P_W-1:0]             md_quot;
  logic [D_W-1:0]             md_rem;

  // shared serial multiply / divide
  ntct_muldiv #(
    .A_W (A_W),
    .B_W (B_W),
    .D_W (D_W)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .quot_o  (md_quot),
    .rem_o   (md_rem)
  );

  // binary search midpoint, rounded up
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (IDX_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign lo_nx   = lo_q + IDX_W'(1);

  // interpolation result, truncated toward zero
  assign isum     = $signed({t1_q[TEMP_W-1], t1_q}) + $signed({1'b0, md_quot[TEMP_W-1:0]});
  assign neg_frac = isum[TEMP_W] && (md_rem != '0);
  assign iadj     = isum + $signed({{TEMP_W{1'b0}}, neg_frac});

  // sequencer: next state and datapath loads
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    r_d      = r_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    t1_d     = t1_q;
    temp_d   = temp_q;
    md_start = 1'b0;
    md_a     = '0;
    md_b     = '0;
    md_d     = '0;
    out_load = 1'b0;
    case (state_q)
      ntct_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (adc_code_i == FULL) begin
            r_d     = ntct_pkg::RES_MAX;
            state_d = ntct_pkg::ST_CLASS;
          end else begin
            md_start = 1'b1;
            md_a     = A_W'(cfg_q);
            md_b     = B_W'(adc_code_i);
            md_d     = D_W'(FULL - adc_code_i);
            state_d  = ntct_pkg::ST_RES;
          end
        end
      end
      ntct_pkg::ST_RES: begin
        if (md_done) begin
          r_d     = (md_quot[P_W-1:OHM_W] != '0) ? ntct_pkg::RES_MAX : md_quot[OHM_W-1:0];
          state_d = ntct_pkg::ST_CLASS;
        end
      end
      ntct_pkg::ST_CLASS: begin
        lo_d = '0;
        hi_d = IDX_W'(ntct_pkg::TABLE_POINTS - 2);
        if (r_q >= ntct_pkg::ROM_OHMS[0]) begin
          temp_d   = ntct_pkg::ROM_CENTI[0];
          status_d = ntct_pkg::RANGE_COLD;
          state_d  = ntct_pkg::ST_FINISH;
        end else if (r_q <= ntct_pkg::ROM_OHMS[ntct_pkg::TABLE_POINTS-1]) begin
          temp_d   = ntct_pkg::ROM_CENTI[ntct_pkg::TABLE_POINTS-1];
          status_d = ntct_pkg::RANGE_HOT;
          state_d  = ntct_pkg::ST_FINISH;
        end else begin
          state_d = ntct_pkg::ST_SEARCH;
        end
      end
      ntct_pkg::ST_SEARCH: begin
        if (lo_q == hi_q) begin
          // segment found: rom[lo] > r >= rom[lo+1]
          md_start = 1'b1;
          md_a     = ntct_pkg::ROM_OHMS[lo_q] - r_q;
          md_b     = B_W'(ntct_pkg::ROM_DT[lo_q]);
          md_d     = ntct_pkg::ROM_OHMS[lo_q] - ntct_pkg::ROM_OHMS[lo_nx];
          t1_d     = ntct_pkg::ROM_CENTI[lo_q];
          state_d  = ntct_pkg::ST_INTERP;
        end else if (ntct_pkg::ROM_OHMS[mid] > r_q) begin
          lo_d = mid;
        end else begin
          hi_d = mid - IDX_W'(1);
        end
      end
      ntct_pkg::ST_INTERP: begin
        if (md_done) begin
          temp_d   = iadj[TEMP_W-1:0];
          status_d = ntct_pkg::RANGE_INTERP;
          state_d  = ntct_pkg::ST_FINISH;
        end
      end
      ntct_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ntct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ntct_pkg::ST_IDLE;
      end
    endcase
  end

  // state, config and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ntct_pkg::ST_IDLE;
      cfg_q       <= ntct_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working and result payload registers
  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    t1_q     <= t1_d;
    temp_q   <= temp_d;
    status_q <= status_d;
    if (out_load) begin
      out_temp_q   <= temp_q;
      out_res_q    <= r_q;
      out_status_q <= status_q;
    end
  end

  assign in_stall_o          = (state_q != ntct_pkg::ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = out_temp_q;
  assign resistance_ohms_o   = out_res_q;
  assign range_status_o      = out_status_q;

  // an accepted item keeps the input stalled on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  // the arithmetic unit only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == ntct_pkg::ST_RES || state_q == ntct_pkg::ST_INTERP))
    else $error("muldiv result arrived in wrong state");

  // search window stays ordered and inside the segment range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ntct_pkg::ST_SEARCH) |->
      (lo_q <= hi_q && hi_q <= IDX_W'(ntct_pkg::TABLE_POINTS - 2)))
    else $error("search window out of range");

  // cold-clamped items carry the first table temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_status_o == ntct_pkg::RANGE_COLD) |->
      temperature_centi_o == ntct_pkg::ROM_CENTI[0])
    else $error("cold clamp temperature mismatch");

  // checks that interpolated items lie strictly inside the table span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_status_o == ntct_pkg::RANGE_INTERP) |->
      (temperature_centi_o > ntct_pkg::ROM_CENTI[0] &&
       temperature_centi_o < ntct_pkg::ROM_CENTI[ntct_pkg::TABLE_POINTS-1]))
    else $error("interpolated temperature outside table span");

endmodule
